// ===== rtl/shrp_pkg.sv =====
// ============================================================================
// Sensor hub report parser package
// Shared types, codes and constants of the sensor hub packet parser.
// ============================================================================
package shrp_pkg;

    // Number of data bytes that are parsed; later bytes only count toward the end.
    localparam logic [14:0] MAX_DATA_BYTES = 15'd128;

    // Header and record constants.
    localparam logic [14:0] HEADER_BYTES   = 15'd4;
    localparam int          FIELD_DEPTH    = 12;
    localparam logic [2:0]  TS_SKIP_BYTES  = 3'd4;

    // Channel numbers.
    localparam logic [7:0] CH_EXEC    = 8'h01;
    localparam logic [7:0] CH_CONTROL = 8'h02;
    localparam logic [7:0] CH_REPORT  = 8'h03;

    // Report and response identifiers.
    localparam logic [7:0] ID_TIMESTAMP    = 8'hFB;
    localparam logic [7:0] ID_GAME_ROT     = 8'h08;
    localparam logic [7:0] ID_LIN_ACCEL    = 8'h04;
    localparam logic [7:0] ID_GYRO         = 8'h02;
    localparam logic [7:0] ID_CMD_RESP     = 8'hF1;
    localparam logic [7:0] ID_FEAT_RESP    = 8'hFC;
    localparam logic [7:0] EXEC_RESET_DONE = 8'h01;

    // Report kinds as given on the result channel.
    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_GAME_ROT = 2'd1,
        KIND_LIN_ACC  = 2'd2,
        KIND_GYRO     = 2'd3
    } t_kind;

    // Packet status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_LEN_ERR = 2'd2
    } t_status;

    // Packet phase, one-hot.
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LEN_HI = 5'b00010,
        S_CHAN   = 5'b00100,
        S_SEQ    = 5'b01000,
        S_DATA   = 5'b10000
    } t_phase;

    // One result beat.
    typedef struct packed {
        t_kind              report_kind;
        logic [1:0]         accuracy;
        logic signed [15:0] value_i;
        logic signed [15:0] value_j;
        logic signed [15:0] value_k;
        logic signed [15:0] value_real;
        logic               packet_end;
        t_status            packet_status;
        logic [7:0]         last_report_id;
        logic               reset_seen;
    } t_result;

    // Total length of a report of the given kind, id byte included.
    function automatic logic [3:0] kind_size(input t_kind kind);
        kind_size = (kind == KIND_GAME_ROT) ? 4'd12 : 4'd10;
    endfunction

endpackage

// ===== rtl/shrp_if.sv =====
// ============================================================================
// Sensor hub report parser channels
// Valid/ready channels for received bytes and for parse results.
// ============================================================================
interface shrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       packet_start;

    modport source (output valid, output rx_byte, output packet_start, input ready);
    modport sink   (input valid, input rx_byte, input packet_start, output ready);
endinterface

interface shrp_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         report_kind;
    logic [1:0]         accuracy;
    logic signed [15:0] value_i;
    logic signed [15:0] value_j;
    logic signed [15:0] value_k;
    logic signed [15:0] value_real;
    logic               packet_end;
    logic [1:0]         packet_status;
    logic [7:0]         last_report_id;
    logic               reset_seen;

    modport source (
        output valid, output report_kind, output accuracy, output value_i,
        output value_j, output value_k, output value_real, output packet_end,
        output packet_status, output last_report_id, output reset_seen,
        input ready
    );
    modport sink (
        input valid, input report_kind, input accuracy, input value_i,
        input value_j, input value_k, input value_real, input packet_end,
        input packet_status, input last_report_id, input reset_seen,
        output ready
    );
endinterface

// ===== rtl/sensor_hub_report_parser_unit.sv =====
// A result beat is valid in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; the single result register is refilled in the cycle
// it is drained, so input stalls only while a result waits and the sink holds off.
// Reset (synchronous, active low) returns the parser to idle and empties the result
// register; the report field bytes are not cleared and need no clearing.
// ============================================================================
// Sensor hub report parser unit
// Parses packet headers and sensor reports from a received byte stream, one byte
// per beat, and returns decoded reports and packet-end status.
// ============================================================================
module sensor_hub_report_parser_unit (
    input logic        i_clk,
    input logic        i_rst_n,
    shrp_in_if.sink    i_in,
    shrp_out_if.source o_out
);
    import shrp_pkg::*;

    // Parser state.
    t_phase      r_phase,     n_phase;
    logic [14:0] r_length,    n_length;
    logic [7:0]  r_channel,   n_channel;
    logic [14:0] r_cursor,    n_cursor;
    logic [3:0]  r_offset,    n_offset;
    t_kind       r_kind,      n_kind;
    logic [2:0]  r_skip,      n_skip;
    logic        r_stopped,   n_stopped;
    logic [7:0]  r_last_id,   n_last_id;
    logic [7:0]  r_field [FIELD_DEPTH];

    // Result register.
    logic        r_out_valid;
    t_result     r_res;
    t_result     n_res;
    logic        n_emit;

    // Field byte write port and merged view with the current byte.
    logic        field_we;
    logic [3:0]  field_idx;
    logic [7:0]  field_now [FIELD_DEPTH];

    logic        accept;
    logic [7:0]  b;
    logic [14:0] dlen;
    logic [14:0] eff;
    logic [15:0] pos_next;
    logic        parse_en;
    t_kind       new_kind;

    assign accept     = i_in.valid && i_in.ready;
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign b          = i_in.rx_byte;

    // Data area bounds; only meaningful in the data phase where length exceeds four.
    assign dlen     = r_length - HEADER_BYTES;
    assign eff      = (dlen < MAX_DATA_BYTES) ? dlen : MAX_DATA_BYTES;
    assign pos_next = {1'b0, r_cursor} + 16'd1;
    assign parse_en = (r_cursor < eff) && !r_stopped;

    // Report id lookup for a byte that may start a report.
    always_comb begin
        unique case (b)
            ID_GAME_ROT:  new_kind = KIND_GAME_ROT;
            ID_LIN_ACCEL: new_kind = KIND_LIN_ACC;
            ID_GYRO:      new_kind = KIND_GYRO;
            default:      new_kind = KIND_NONE;
        endcase
    end

    // Stored field bytes with the byte being written this cycle folded in.
    always_comb begin
        for (int i = 0; i < FIELD_DEPTH; i++) begin
            field_now[i] = (field_we && field_idx == 4'(i)) ? b : r_field[i];
        end
    end

    // Next-state and result logic for one accepted byte.
    always_comb begin
        n_phase   = r_phase;
        n_length  = r_length;
        n_channel = r_channel;
        n_cursor  = r_cursor;
        n_offset  = r_offset;
        n_kind    = r_kind;
        n_skip    = r_skip;
        n_stopped = r_stopped;
        n_last_id = r_last_id;
        field_we  = 1'b0;
        field_idx = r_offset;
        n_emit    = 1'b0;
        n_res     = '0;

        if (i_in.packet_start) begin
            // A start byte abandons any packet and carries the low length byte.
            n_phase   = S_LEN_HI;
            n_length  = {7'd0, b};
            n_channel = '0;
            n_cursor  = '0;
            n_offset  = '0;
            n_kind    = KIND_NONE;
            n_skip    = '0;
            n_stopped = 1'b0;
            n_last_id = '0;
        end else begin
            unique case (r_phase)
                S_IDLE: begin
                end
                S_LEN_HI: begin
                    n_length = {b[6:0], r_length[7:0]};
                    n_phase  = S_CHAN;
                end
                S_CHAN: begin
                    n_channel = b;
                    n_phase   = S_SEQ;
                end
                S_SEQ: begin
                    // The packet ends here unless it carries data bytes.
                    if (r_length > HEADER_BYTES) begin
                        n_phase = S_DATA;
                    end else begin
                        n_phase          = S_IDLE;
                        n_emit           = 1'b1;
                        n_res.packet_end = 1'b1;
                        if (r_length == '0) begin
                            n_res.packet_status = ST_EMPTY;
                        end else if (r_length < HEADER_BYTES) begin
                            n_res.packet_status = ST_LEN_ERR;
                        end else begin
                            n_res.packet_status = ST_OK;
                        end
                    end
                end
                S_DATA: begin
                    if (parse_en) begin
                        if (r_channel == CH_REPORT) begin
                            if (r_skip != '0) begin
                                n_skip = r_skip - 3'd1;
                            end else if (r_kind != KIND_NONE) begin
                                // Collect report bytes; emit when the last one lands.
                                field_we  = 1'b1;
                                field_idx = r_offset;
                                n_offset  = r_offset + 4'd1;
                                if (n_offset >= kind_size(r_kind)) begin
                                    n_emit            = 1'b1;
                                    n_res.report_kind = r_kind;
                                    n_res.accuracy    = field_now[2][1:0];
                                    n_res.value_i     = {field_now[5], field_now[4]};
                                    n_res.value_j     = {field_now[7], field_now[6]};
                                    n_res.value_k     = {field_now[9], field_now[8]};
                                    if (r_kind == KIND_GAME_ROT) begin
                                        n_res.value_real = {field_now[11], field_now[10]};
                                    end
                                    n_last_id = field_now[0];
                                    n_kind    = KIND_NONE;
                                    n_offset  = '0;
                                end
                            end else if (r_cursor == '0 && b == ID_TIMESTAMP) begin
                                n_skip = TS_SKIP_BYTES;
                            end else if (new_kind != KIND_NONE) begin
                                // A report that would overrun the parsed area stops parsing.
                                if ({1'b0, r_cursor} + 16'(kind_size(new_kind))
                                        <= {1'b0, eff}) begin
                                    n_kind    = new_kind;
                                    field_we  = 1'b1;
                                    field_idx = '0;
                                    n_offset  = 4'd1;
                                end else begin
                                    n_stopped = 1'b1;
                                end
                            end
                        end else if (r_channel == CH_CONTROL) begin
                            if (r_cursor == '0 && (b == ID_CMD_RESP || b == ID_FEAT_RESP)) begin
                                n_last_id = b;
                            end
                        end else if (r_channel == CH_EXEC) begin
                            if (r_cursor == '0 && b == EXEC_RESET_DONE) begin
                                n_last_id = EXEC_RESET_DONE;
                            end
                        end
                    end

                    n_cursor = pos_next[14:0];

                    // Packet end, counted over all data bytes including discarded ones.
                    if (pos_next >= {1'b0, dlen}) begin
                        n_phase             = S_IDLE;
                        n_emit              = 1'b1;
                        n_res.packet_end    = 1'b1;
                        n_res.packet_status = ST_OK;
                        if (r_channel == CH_EXEC) begin
                            n_res.last_report_id = '0;
                            n_res.reset_seen     = (n_last_id == EXEC_RESET_DONE);
                        end else begin
                            n_res.last_report_id = n_last_id;
                        end
                    end
                end
                default: begin
                    n_phase = S_IDLE;
                end
            endcase
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= S_IDLE;
            r_length  <= '0;
            r_channel <= '0;
            r_cursor  <= '0;
            r_offset  <= '0;
            r_kind    <= KIND_NONE;
            r_skip    <= '0;
            r_stopped <= 1'b0;
            r_last_id <= '0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_length  <= n_length;
            r_channel <= n_channel;
            r_cursor  <= n_cursor;
            r_offset  <= n_offset;
            r_kind    <= n_kind;
            r_skip    <= n_skip;
            r_stopped <= n_stopped;
            r_last_id <= n_last_id;
        end
    end

    // Report field bytes, one write port.
    always_ff @(posedge i_clk) begin
        if (accept && field_we) begin
            r_field[field_idx] <= b;
        end
    end

    // Result register: refilled on accept, emptied when the sink takes the beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= n_emit;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_res <= n_res;
        end
    end

    // Result channel.
    assign o_out.valid          = r_out_valid;
    assign o_out.report_kind    = r_res.report_kind;
    assign o_out.accuracy       = r_res.accuracy;
    assign o_out.value_i        = r_res.value_i;
    assign o_out.value_j        = r_res.value_j;
    assign o_out.value_k        = r_res.value_k;
    assign o_out.value_real     = r_res.value_real;
    assign o_out.packet_end     = r_res.packet_end;
    assign o_out.packet_status  = r_res.packet_status;
    assign o_out.last_report_id = r_res.last_report_id;
    assign o_out.reset_seen     = r_res.reset_seen;

endmodule

// ===== tb/sv/shrp_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Sensor hub report parser checker
// Watches the byte and result channels of the parser and keeps its own model
// of the packet and report parsing state. Every accepted byte beat updates
// that model. Any result it produces is queued. Every accepted result beat
// is compared field by field with the oldest queued result.
// ============================================================================
module shrp_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    shrp_in_if   i_byte_ch,
    shrp_out_if  i_res_ch,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);
    import shrp_pkg::*;

    localparam int GAME_ROT_LEN = 12;
    localparam int AXIS_LEN     = 10;

    // Parser state as the block should hold it.
    logic [2:0]  hdr_cnt;
    logic [14:0] pkt_len;
    logic [7:0]  chan_num;
    logic [14:0] data_pos;
    logic [3:0]  rec_off;
    t_kind       rec_kind;
    logic [2:0]  ts_skip;
    logic        parse_halt;
    logic [7:0]  rec_bytes [FIELD_DEPTH];
    logic [7:0]  last_rec_id;

    t_result     parse_results_q [$];
    int          fail_total;
    int          checked_total;

    initial begin
        fail_total    = 0;
        checked_total = 0;
        o_fail_count  = 0;
        o_pending     = 0;
        o_checked     = 0;
    end

    // Full length of a report record, id byte included.
    function automatic int record_len(input t_kind kind);
        return (kind == KIND_GAME_ROT) ? GAME_ROT_LEN : AXIS_LEN;
    endfunction

    // Advance the parsing state by one byte and queue the result it causes.
    task automatic parse_rx_byte(input logic [7:0] b, input logic start);
        t_result beat;
        bit      emit;
        int      body_len;
        int      parse_len;
        int      pos;
        t_kind   k;
        beat = '0;
        emit = 1'b0;
        if (start) begin
            pkt_len     = {7'd0, b};
            hdr_cnt     = 3'd1;
            chan_num    = 8'd0;
            data_pos    = 15'd0;
            rec_off     = 4'd0;
            rec_kind    = KIND_NONE;
            ts_skip     = 3'd0;
            parse_halt  = 1'b0;
            last_rec_id = 8'd0;
        end else if (hdr_cnt == 3'd1) begin
            pkt_len = {b[6:0], pkt_len[7:0]};
            hdr_cnt = 3'd2;
        end else if (hdr_cnt == 3'd2) begin
            chan_num = b;
            hdr_cnt  = 3'd3;
        end else if (hdr_cnt == 3'd3) begin
            // Sequence byte: a packet of four bytes or fewer ends here.
            if (pkt_len > HEADER_BYTES) begin
                hdr_cnt = 3'd4;
            end else begin
                hdr_cnt            = 3'd0;
                beat.packet_end    = 1'b1;
                beat.packet_status = (pkt_len == 15'd0) ? ST_EMPTY :
                                     (pkt_len < HEADER_BYTES) ? ST_LEN_ERR : ST_OK;
                emit               = 1'b1;
            end
        end else if (hdr_cnt == 3'd4) begin
            body_len  = int'(pkt_len) - int'(HEADER_BYTES);
            parse_len = (body_len < int'(MAX_DATA_BYTES)) ? body_len : int'(MAX_DATA_BYTES);
            pos       = int'(data_pos);
            if (pos < parse_len && !parse_halt) begin
                if (chan_num == CH_REPORT) begin
                    if (ts_skip != 3'd0) begin
                        ts_skip = ts_skip - 3'd1;
                    end else if (rec_kind != KIND_NONE) begin
                        // Collect the record; it completes at its full length.
                        if (rec_off < FIELD_DEPTH) rec_bytes[rec_off] = b;
                        rec_off = rec_off + 4'd1;
                        if (int'(rec_off) >= record_len(rec_kind)) begin
                            beat.report_kind = rec_kind;
                            beat.accuracy    = rec_bytes[2][1:0];
                            beat.value_i     = {rec_bytes[5], rec_bytes[4]};
                            beat.value_j     = {rec_bytes[7], rec_bytes[6]};
                            beat.value_k     = {rec_bytes[9], rec_bytes[8]};
                            beat.value_real  = (rec_kind == KIND_GAME_ROT) ?
                                               {rec_bytes[11], rec_bytes[10]} : 16'sd0;
                            last_rec_id      = rec_bytes[0];
                            rec_kind         = KIND_NONE;
                            rec_off          = 4'd0;
                            emit             = 1'b1;
                        end
                    end else if (pos == 0 && b == ID_TIMESTAMP) begin
                        ts_skip = TS_SKIP_BYTES;
                    end else begin
                        case (b)
                            ID_GAME_ROT:  k = KIND_GAME_ROT;
                            ID_LIN_ACCEL: k = KIND_LIN_ACC;
                            ID_GYRO:      k = KIND_GYRO;
                            default:      k = KIND_NONE;
                        endcase
                        // A record that cannot fit stops parsing for the packet.
                        if (k != KIND_NONE) begin
                            if (pos + record_len(k) <= parse_len) begin
                                rec_kind     = k;
                                rec_bytes[0] = b;
                                rec_off      = 4'd1;
                            end else begin
                                parse_halt = 1'b1;
                            end
                        end
                    end
                end else if (chan_num == CH_CONTROL) begin
                    if (pos == 0 && (b == ID_CMD_RESP || b == ID_FEAT_RESP)) last_rec_id = b;
                end else if (chan_num == CH_EXEC) begin
                    if (pos == 0 && b == EXEC_RESET_DONE) last_rec_id = EXEC_RESET_DONE;
                end
            end
            data_pos = data_pos + 15'd1;
            if (pos + 1 >= body_len) begin
                hdr_cnt             = 3'd0;
                beat.packet_end     = 1'b1;
                beat.packet_status  = ST_OK;
                beat.last_report_id = (chan_num == CH_EXEC) ? 8'd0 : last_rec_id;
                beat.reset_seen     = (chan_num == CH_EXEC) && (last_rec_id == EXEC_RESET_DONE);
                emit                = 1'b1;
            end
        end
        if (emit) parse_results_q.push_back(beat);
    endtask

    // Compare one result field and log a mismatch.
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            fail_total++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Results are matched before new bytes are modeled, so a beat never meets
    // an expectation queued at the same edge.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            hdr_cnt     = 3'd0;
            pkt_len     = 15'd0;
            chan_num    = 8'd0;
            data_pos    = 15'd0;
            rec_off     = 4'd0;
            rec_kind    = KIND_NONE;
            ts_skip     = 3'd0;
            parse_halt  = 1'b0;
            last_rec_id = 8'd0;
            parse_results_q.delete();
        end else begin
            if (i_res_ch.valid && i_res_ch.ready) begin
                if (parse_results_q.size() == 0) begin
                    fail_total++;
                    $display("%0t: result beat with nothing expected: kind %0d, end %0b",
                             $time, i_res_ch.report_kind, i_res_ch.packet_end);
                end else begin
                    want = parse_results_q.pop_front();
                    check_field("report_kind", 16'(want.report_kind),
                                16'(i_res_ch.report_kind));
                    check_field("accuracy", 16'(want.accuracy), 16'(i_res_ch.accuracy));
                    check_field("value_i", want.value_i, i_res_ch.value_i);
                    check_field("value_j", want.value_j, i_res_ch.value_j);
                    check_field("value_k", want.value_k, i_res_ch.value_k);
                    check_field("value_real", want.value_real, i_res_ch.value_real);
                    check_field("packet_end", 16'(want.packet_end),
                                16'(i_res_ch.packet_end));
                    check_field("packet_status", 16'(want.packet_status),
                                16'(i_res_ch.packet_status));
                    check_field("last_report_id", 16'(want.last_report_id),
                                16'(i_res_ch.last_report_id));
                    check_field("reset_seen", 16'(want.reset_seen),
                                16'(i_res_ch.reset_seen));
                    checked_total++;
                end
            end
            if (i_byte_ch.valid && i_byte_ch.ready)
                parse_rx_byte(i_byte_ch.rx_byte, i_byte_ch.packet_start);
        end
        o_fail_count <= fail_total;
        o_pending    <= parse_results_q.size();
        o_checked    <= checked_total;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Sensor hub report parser testbench
// Sends packet byte streams into the parser: first hand-built packets for the
// header lengths, channels and report corner cases, then random packets made
// mostly of well-formed reports, with random gaps on both channels. The
// checker beside the block predicts and compares every result beat.
// ============================================================================
module tb_top;
    import shrp_pkg::*;

    localparam int RANDOM_ITEMS = 300;
    localparam int DRAIN_CYCLES = 20;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int tx_idle_pct;
    int rx_idle_pct;
    int pkt_count;
    int rnd_items;
    int total_bytes;
    int fail_count;
    int pending;
    int checked;

    logic [7:0] pkt_data [$];

    shrp_in_if  in_ch ();
    shrp_out_if out_ch ();

    sensor_hub_report_parser_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    shrp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_ch    (in_ch),
        .i_res_ch     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result sink with random back-pressure.
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Send one byte beat, with random gaps ahead of it, and wait until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic start);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.rx_byte      <= b;
        in_ch.packet_start <= start;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        total_bytes++;
    endtask

    // Header with the given length, then ndata data bytes taken from pkt_data
    // and padded with random bytes.
    task automatic send_packet(input logic [14:0] len, input logic [7:0] chan, input int ndata);
        send_byte(len[7:0], 1'b1);
        send_byte({1'($urandom_range(1)), len[14:8]}, 1'b0);
        send_byte(chan, 1'b0);
        send_byte(8'($urandom), 1'b0);
        for (int i = 0; i < ndata; i++)
            send_byte((i < pkt_data.size()) ? pkt_data[i] : 8'($urandom), 1'b0);
        pkt_data.delete();
        pkt_count++;
        rnd_items += 4 + ndata;
    endtask

    // Whole packet sized to fit the staged data exactly.
    task automatic send_sized(input logic [7:0] chan);
        int n;
        n = pkt_data.size();
        send_packet(15'(n + 4), chan, n);
    endtask

    // Stage a report record; fill < 0 gives random values, else every value is fill.
    task automatic add_report(input logic [7:0] id, input logic [7:0] status, input int fill);
        int nval;
        nval = (id == ID_GAME_ROT) ? 8 : 6;
        pkt_data.push_back(id);
        pkt_data.push_back(8'($urandom));
        pkt_data.push_back(status);
        pkt_data.push_back(8'($urandom));
        for (int i = 0; i < nval; i++)
            pkt_data.push_back((fill < 0) ? 8'($urandom) : (i[0] ? fill[15:8] : fill[7:0]));
    endtask

    task automatic add_timestamp();
        pkt_data.push_back(ID_TIMESTAMP);
        repeat (4) pkt_data.push_back(8'($urandom));
    endtask

    function automatic logic [7:0] pick_report_id();
        case ($urandom_range(2))
            0:       return ID_GAME_ROT;
            1:       return ID_LIN_ACCEL;
            default: return ID_GYRO;
        endcase
    endfunction

    // One random packet, mostly well-formed reports, sometimes cut short, padded,
    // abandoned, no longer than a header, or replaced by a stray byte.
    task automatic random_packet();
        int         pick;
        int         len;
        int         ndata;
        int         target;
        int         cut;
        logic [7:0] chan;
        pick = $urandom_range(99);
        if (pick < 3) begin
            send_byte(8'($urandom), 1'b0);
            return;
        end
        if (pick < 8) begin
            send_packet(15'($urandom_range(4)), 8'($urandom), 0);
            return;
        end
        pick = $urandom_range(99);
        chan = (pick < 70) ? CH_REPORT : (pick < 80) ? CH_CONTROL :
               (pick < 88) ? CH_EXEC : 8'($urandom);
        if (chan == CH_REPORT) begin
            if ($urandom_range(1)) add_timestamp();
            repeat ($urandom_range(1, 4)) begin
                case ($urandom_range(4))
                    0, 1, 2: add_report(pick_report_id(), 8'($urandom), -1);
                    3:       pkt_data.push_back(8'($urandom));
                    default: pkt_data.push_back(ID_TIMESTAMP);
                endcase
            end
        end else begin
            pick = $urandom_range(2);
            if (chan == CH_CONTROL)
                pkt_data.push_back((pick == 0) ? ID_CMD_RESP :
                                   (pick == 1) ? ID_FEAT_RESP : 8'($urandom));
            else if (chan == CH_EXEC)
                pkt_data.push_back((pick < 2) ? EXEC_RESET_DONE : 8'($urandom));
            repeat ($urandom_range(6)) pkt_data.push_back(8'($urandom));
        end
        // Now and then a packet runs past the parsed area.
        if (pkt_count % 10 == 4) begin
            target = $urandom_range(130, 176);
            while (pkt_data.size() < target) add_report(pick_report_id(), 8'($urandom), -1);
        end
        len  = pkt_data.size() + 4;
        pick = $urandom_range(99);
        if (pick < 15 && pkt_data.size() > 0) begin
            cut = (pkt_data.size() < 8) ? pkt_data.size() : 8;
            len -= $urandom_range(1, cut);
        end else if (pick < 25) begin
            len += $urandom_range(1, 6);
        end
        ndata = (len > 4) ? len - 4 : 0;
        // The next packet start abandons this one.
        if ($urandom_range(99) < 5 && ndata > 1) ndata = $urandom_range(ndata - 1);
        send_packet(15'(len), chan, ndata);
    endtask

    // Stimulus and verdict.
    initial begin
        in_ch.valid        = 1'b0;
        in_ch.rx_byte      = 8'd0;
        in_ch.packet_start = 1'b0;
        out_ch.ready       = 1'b0;
        i_rst_n            = 1'b0;
        tx_idle_pct        = 18;
        rx_idle_pct        = 84;
        pkt_count          = 0;
        rnd_items          = 0;
        total_bytes        = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Stray bytes outside any packet are ignored.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        // Empty, short and header-only packets.
        for (int l = 0; l <= 4; l++) send_packet(15'(l), CH_REPORT, 0);
        // Largest length, abandoned by the next start.
        send_packet(15'h7FFF, CH_REPORT, 3);
        // Control responses, and a response code in the wrong place.
        pkt_data.push_back(ID_CMD_RESP);
        pkt_data.push_back(8'h00);
        send_sized(CH_CONTROL);
        pkt_data.push_back(ID_FEAT_RESP);
        send_sized(CH_CONTROL);
        pkt_data.push_back(8'h00);
        pkt_data.push_back(ID_CMD_RESP);
        send_sized(CH_CONTROL);
        // Executable channel with and without the reset-complete byte first.
        pkt_data.push_back(EXEC_RESET_DONE);
        send_sized(CH_EXEC);
        pkt_data.push_back(8'h00);
        pkt_data.push_back(EXEC_RESET_DONE);
        send_sized(CH_EXEC);
        // Timestamp and reports with extreme values and accuracies.
        add_timestamp();
        add_report(ID_GAME_ROT, 8'hFF, 16'h8000);
        add_report(ID_LIN_ACCEL, 8'h00, 16'h7FFF);
        send_sized(CH_REPORT);
        // Unknown bytes ahead of a gyro report that ends with the packet.
        pkt_data.push_back(8'h55);
        pkt_data.push_back(ID_TIMESTAMP);
        pkt_data.push_back(8'h00);
        add_report(ID_GYRO, 8'h02, 16'hFFFF);
        send_sized(CH_REPORT);
        // A report that would run past the packet end stops parsing.
        add_report(ID_GYRO, 8'h01, -1);
        pkt_data.push_back(ID_LIN_ACCEL);
        add_report(ID_GAME_ROT, 8'h03, -1);
        send_packet(15'(4 + 10 + 6), CH_REPORT, 16);
        // Timestamp cut by the packet end.
        pkt_data.push_back(ID_TIMESTAMP);
        pkt_data.push_back(ID_GAME_ROT);
        pkt_data.push_back(ID_GYRO);
        send_sized(CH_REPORT);
        // Restart in the middle of a report.
        add_report(ID_GAME_ROT, 8'h02, -1);
        send_packet(15'(4 + 12), CH_REPORT, 7);
        // Report bytes on another channel are not decoded.
        add_report(ID_GYRO, 8'h03, -1);
        send_sized(8'h05);

        // Random packets in three stall settings.
        rnd_items = 0;
        while (rnd_items < RANDOM_ITEMS) begin
            if (rnd_items < RANDOM_ITEMS / 3) begin
                tx_idle_pct = 18;
                rx_idle_pct = 84;
            end else if (rnd_items < 2 * RANDOM_ITEMS / 3) begin
                tx_idle_pct = 84;
                rx_idle_pct = 18;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            random_packet();
        end
        in_ch.valid <= 1'b0;

        // Drain outstanding results, then watch for stray beats.
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes in %0d packets; %0d result beats compared, %0d mismatches.",
                 total_bytes, pkt_count, checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Run limit far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("Timeout with %0d results still expected.", pending);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
